// ----- hw/rtl/gbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg : shared types and constants
// Box suppression sizes, command codes and sequencer states.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MaxBoxes     = 64;
    localparam int CoordW       = 16;
    localparam int ScoreW       = 16;
    localparam int ThreshW      = 16;
    localparam int IndexW       = 6;
    localparam logic [ThreshW-1:0] ThreshReset = 16'd32768;
    localparam logic signed [17:0] OnePixel = 18'sd16;

    typedef enum logic {
        t_CMD_LOAD  = 1'b0,
        t_CMD_START = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_SCAN,
        t_ST_EMIT,
        t_ST_TEST,
        t_ST_EMPTY
    } t_state;

    typedef struct packed {
        logic signed [CoordW-1:0] bottom;
        logic signed [CoordW-1:0] right;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] left;
    } t_box;

endpackage

// ----- hw/rtl/greedy_box_suppression.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression : greedy non-maximum suppression over a box store
// Loads boxes, then on start emits kept box indices best first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one transaction per command.
//   A load (command 0) writes one box and score into the store on acceptance,
//   so loads can run back to back; loads beyond MAX_BOXES are discarded.
//   A load gives no result.
//   A start (command 1) runs suppression over the n loaded boxes. Each round
//   scans the store for the best remaining score (one memory read per cycle),
//   marks it, streams every unmarked entry through the shared overlap unit,
//   then offers the kept index, flagged last once nothing remains. Input is
//   not ready until the last result is taken.
//   An empty start yields one result with none_kept and is_last set, valid
//   the cycle after the start.
//   Output channel (o_valid/i_ready): a result waits unchanged while the
//   receiver stalls; the sequencer holds until it is taken. Reset clears
//   the count, marks and sequencer; threshold goes to 0.5. The user must
//   write the threshold via i_cfg_we/i_cfg_data when idle; not enforced.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
    parameter int MAX_BOXES = gbs_pkg::MaxBoxes
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic signed [15:0]            i_left,
    input  logic signed [15:0]            i_top,
    input  logic signed [15:0]            i_right,
    input  logic signed [15:0]            i_bottom,
    input  logic [15:0]                   i_score,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [5:0]                    o_kept_index,
    output logic                          o_is_last,
    output logic                          o_none_kept
);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    // stores
    gbs_pkg::t_box    box_mem   [MAX_BOXES];
    logic [15:0]      score_mem [MAX_BOXES];

    gbs_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [MAX_BOXES-1:0] r_marks;
    logic [15:0]      r_thresh;
    logic [CW-1:0]    r_ptr;         // scan / issue pointer
    logic             r_rd_v;        // read data valid
    logic [AW-1:0]    r_rd_idx;
    logic [15:0]      r_rd_score;
    gbs_pkg::t_box    r_rd_box;
    logic             r_found;
    logic [AW-1:0]    r_best;
    logic [15:0]      r_best_score;
    gbs_pkg::t_box    r_best_box;
    logic [AW-1:0]    r_pipe_idx [4];
    logic [CW-1:0]    r_pending;
    logic [CW-1:0]    r_remain;      // entries neither kept nor dropped

    logic             ov_valid, ov_drop;
    logic             in_acc, out_acc, scan_rd, test_rd;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_state == gbs_pkg::t_ST_IDLE);
    assign scan_rd = (r_state == gbs_pkg::t_ST_SCAN) && (r_ptr < r_count);
    assign test_rd = (r_state == gbs_pkg::t_ST_TEST) && (r_ptr < r_count);

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == gbs_pkg::t_CMD_LOAD && r_count < CW'(MAX_BOXES)) begin
            box_mem[r_count[AW-1:0]]   <= '{bottom: i_bottom, right: i_right,
                                            top: i_top, left: i_left};
            score_mem[r_count[AW-1:0]] <= i_score;
        end
        r_rd_box   <= box_mem[r_ptr[AW-1:0]];
        r_rd_score <= score_mem[r_ptr[AW-1:0]];
        r_rd_idx   <= r_ptr[AW-1:0];
    end

    gbs_overlap u_overlap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_v && r_state == gbs_pkg::t_ST_TEST && !r_marks[r_rd_idx]),
        .i_a      (r_best_box),
        .i_b      (r_rd_box),
        .i_thresh (r_thresh),
        .o_valid  (ov_valid),
        .o_drop   (ov_drop)
    );

    always_ff @(posedge i_clk) begin
        r_pipe_idx[0] <= r_rd_idx;
        for (int k = 1; k < 4; k++) r_pipe_idx[k] <= r_pipe_idx[k-1];
    end

    // next state: scan for the best, test the rest against it, then emit
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbs_pkg::t_ST_IDLE:
                if (in_acc && i_command == gbs_pkg::t_CMD_START)
                    n_state = (r_count == '0) ? gbs_pkg::t_ST_EMPTY : gbs_pkg::t_ST_SCAN;
            gbs_pkg::t_ST_SCAN:
                if (r_ptr == r_count && !r_rd_v)
                    n_state = r_found ? gbs_pkg::t_ST_TEST : gbs_pkg::t_ST_IDLE;
            gbs_pkg::t_ST_TEST:
                if (r_ptr == r_count && !r_rd_v && r_pending == '0 && !ov_valid)
                    n_state = gbs_pkg::t_ST_EMIT;
            gbs_pkg::t_ST_EMIT:
                if (out_acc)
                    n_state = (r_remain == '0) ? gbs_pkg::t_ST_IDLE : gbs_pkg::t_ST_SCAN;
            gbs_pkg::t_ST_EMPTY:
                if (out_acc) n_state = gbs_pkg::t_ST_IDLE;
            default: n_state = gbs_pkg::t_ST_IDLE;
        endcase
    end

    // outputs: result comes straight from the held best index; the round's
    // suppressions are done by then, so last is known
    always_comb begin
        o_valid      = (r_state == gbs_pkg::t_ST_EMIT) || (r_state == gbs_pkg::t_ST_EMPTY);
        o_none_kept  = (r_state == gbs_pkg::t_ST_EMPTY);
        o_kept_index = (r_state == gbs_pkg::t_ST_EMPTY) ? 6'd0 : 6'(r_best);
        o_is_last    = (r_state == gbs_pkg::t_ST_EMPTY) ||
                       ((r_state == gbs_pkg::t_ST_EMIT) && (r_remain == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbs_pkg::t_ST_IDLE;
            r_count  <= '0;
            r_marks  <= '0;
            r_thresh <= gbs_pkg::ThreshReset;
            r_ptr    <= '0;
            r_rd_v   <= 1'b0;
            r_found  <= 1'b0;
            r_pending <= '0;
            r_remain <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_thresh <= i_cfg_data;
            r_rd_v <= scan_rd || test_rd;
            if (in_acc && i_command == gbs_pkg::t_CMD_LOAD && r_count < CW'(MAX_BOXES))
                r_count <= r_count + 1'b1;
            case (r_state)
                gbs_pkg::t_ST_IDLE: begin
                    r_marks <= '0;
                    r_ptr   <= '0;
                    r_found <= 1'b0;
                    r_remain <= r_count;
                end
                gbs_pkg::t_ST_SCAN: begin
                    if (scan_rd) r_ptr <= r_ptr + 1'b1;
                    if (r_rd_v && !r_marks[r_rd_idx] &&
                        (!r_found || r_rd_score > r_best_score)) begin
                        r_found      <= 1'b1;
                        r_best       <= r_rd_idx;
                        r_best_score <= r_rd_score;
                        r_best_box   <= r_rd_box;
                    end
                    if (n_state == gbs_pkg::t_ST_TEST) begin
                        r_marks[r_best] <= 1'b1;
                        r_ptr <= '0;
                        r_remain <= r_remain - 1'b1;
                    end
                    if (n_state == gbs_pkg::t_ST_IDLE) r_count <= '0;
                end
                gbs_pkg::t_ST_EMIT: begin
                    if (out_acc && r_remain == '0) r_count <= '0;
                end
                gbs_pkg::t_ST_TEST: begin
                    if (test_rd) r_ptr <= r_ptr + 1'b1;
                    if (r_rd_v && !r_marks[r_rd_idx]) begin
                        if (!ov_valid) r_pending <= r_pending + 1'b1;
                    end else if (ov_valid) r_pending <= r_pending - 1'b1;
                    if (ov_valid && ov_drop) begin
                        r_marks[r_pipe_idx[3]] <= 1'b1;
                        r_remain <= r_remain - 1'b1;
                    end
                    if (n_state == gbs_pkg::t_ST_EMIT) begin
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                    end
                end
                gbs_pkg::t_ST_EMPTY: r_ptr <= '0;
                default: r_ptr <= '0;
            endcase
        end
    end
endmodule

// ----- hw/rtl/gbs_overlap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_overlap : shared overlap test unit
// Pipelined intersection-over-union threshold test, four register stages.
// ----------------------------------------------------------------------------
module gbs_overlap (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  gbs_pkg::t_box                i_a,
    input  gbs_pkg::t_box                i_b,
    input  logic [gbs_pkg::ThreshW-1:0]  i_thresh,
    output logic                         o_valid,
    output logic                         o_drop
);
    // stage 1: extents
    logic signed [17:0] r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    // stage 2: areas
    logic signed [35:0] r_inter, r_area_a, r_area_b;
    // stage 3: union
    logic signed [37:0] r_uni;
    logic signed [35:0] r_inter3;
    // stage 4: products
    logic signed [53:0] r_lhs;
    logic signed [55:0] r_rhs;
    logic               r_zero, r_neg;
    logic [3:0]         r_v;

    logic signed [17:0] n_iw, n_ih;
    logic signed [15:0] x1, y1, x2, y2;

    always_comb begin
        x1 = (i_a.left > i_b.left) ? i_a.left : i_b.left;
        y1 = (i_a.top > i_b.top) ? i_a.top : i_b.top;
        x2 = (i_a.right < i_b.right) ? i_a.right : i_b.right;
        y2 = (i_a.bottom < i_b.bottom) ? i_a.bottom : i_b.bottom;
        n_iw = 18'(x2) - 18'(x1) + gbs_pkg::OnePixel;
        n_ih = 18'(y2) - 18'(y1) + gbs_pkg::OnePixel;
    end

    always_ff @(posedge i_clk) begin
        r_iw <= n_iw[17] ? 18'sd0 : n_iw;
        r_ih <= n_ih[17] ? 18'sd0 : n_ih;
        r_aw <= 18'(i_a.right) - 18'(i_a.left) + gbs_pkg::OnePixel;
        r_ah <= 18'(i_a.bottom) - 18'(i_a.top) + gbs_pkg::OnePixel;
        r_bw <= 18'(i_b.right) - 18'(i_b.left) + gbs_pkg::OnePixel;
        r_bh <= 18'(i_b.bottom) - 18'(i_b.top) + gbs_pkg::OnePixel;
        r_inter  <= r_iw * r_ih;
        r_area_a <= r_aw * r_ah;
        r_area_b <= r_bw * r_bh;
        r_uni    <= 38'(r_area_a) + 38'(r_area_b) - 38'(r_inter);
        r_inter3 <= r_inter;
        r_lhs    <= 54'(r_inter3) <<< 16;
        r_rhs    <= $signed({1'b0, i_thresh}) * r_uni;
        r_zero   <= (r_uni == 38'sd0);
        r_neg    <= r_uni[37];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign o_valid = r_v[3];
    assign o_drop  = r_zero || (!r_neg && (56'(r_lhs) > r_rhs));
endmodule

// ----- sim/greedy_box_suppression_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb : self-checking bench for box suppression
// Streams box loads and start commands with random gaps and receiver stalls,
// predicts kept indices with an independent greedy suppression routine and
// compares every result transaction in order.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;

    // Expected result of one output transaction
    typedef struct {
        logic [5:0] kept_index;
        logic       is_last;
        logic       none_kept;
    } t_kept;

    // Scoreboard: holds its own copy of the store and threshold, runs the
    // greedy pass on every start and queues the kept indices.
    class kept_scoreboard;
        gbs_pkg::t_box     boxes[gbs_pkg::MaxBoxes];
        logic [15:0]       scores[gbs_pkg::MaxBoxes];
        int                count;
        logic [15:0]       thresh;
        t_kept             pending[$];
        int                errors;
        int                checked;

        function new();
            count = 0;
            thresh = gbs_pkg::ThreshReset;
            errors = 0;
            checked = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        function longint box_area(gbs_pkg::t_box b);
            longint w;
            longint h;
            w = longint'(b.right) - longint'(b.left) + 16;
            h = longint'(b.bottom) - longint'(b.top) + 16;
            return w * h;
        endfunction

        // True when box b overlaps kept box a by more than the threshold
        function bit overlaps_too_much(gbs_pkg::t_box a, gbs_pkg::t_box b);
            longint x1;
            longint y1;
            longint x2;
            longint y2;
            longint w;
            longint h;
            longint inter;
            longint uni;
            x1 = (a.left > b.left) ? a.left : b.left;
            y1 = (a.top > b.top) ? a.top : b.top;
            x2 = (a.right < b.right) ? a.right : b.right;
            y2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
            w = x2 - x1 + 16;
            h = y2 - y1 + 16;
            if (w < 0) w = 0;
            if (h < 0) h = 0;
            inter = w * h;
            uni = box_area(a) + box_area(b) - inter;
            if (uni == 0) return 1;
            if (uni < 0) return 0;
            return (inter * 65536) > (longint'(thresh) * uni);
        endfunction

        function void note_command(gbs_pkg::t_cmd cmd, gbs_pkg::t_box b, logic [15:0] s);
            logic [63:0] gone;
            int best;
            bit found;
            t_kept k;
            if (cmd == gbs_pkg::t_CMD_LOAD) begin
                if (count < gbs_pkg::MaxBoxes) begin
                    boxes[count] = b;
                    scores[count] = s;
                    count++;
                end
                return;
            end
            if (count == 0) begin
                k.kept_index = '0; k.is_last = 1'b1; k.none_kept = 1'b1;
                pending.insert(pending.size(), k);
                return;
            end
            gone = '0;
            forever begin
                found = 0;
                best = 0;
                for (int i = 0; i < count; i++) begin
                    if (!gone[i] && (!found || scores[i] > scores[best])) begin
                        best = i;
                        found = 1;
                    end
                end
                if (!found) break;
                gone[best] = 1'b1;
                k.kept_index = best[5:0]; k.is_last = 1'b0; k.none_kept = 1'b0;
                pending.insert(pending.size(), k);
                for (int i = 0; i < count; i++)
                    if (!gone[i] && overlaps_too_much(boxes[best], boxes[i]))
                        gone[i] = 1'b1;
            end
            pending[pending.size() - 1].is_last = 1'b1;
            count = 0;
        endfunction

        task check_result(logic [5:0] idx, logic last, logic none);
            t_kept k;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result idx=%0d", idx));
                return;
            end
            k = pending.pop_front();
            if (idx !== k.kept_index || last !== k.is_last || none !== k.none_kept)
                report_mismatch($sformatf("got idx=%0d last=%0b none=%0b, want %0d/%0b/%0b",
                    idx, last, none, k.kept_index, k.is_last, k.none_kept));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        command = 0;
    logic [15:0] left = 0, top = 0, right = 0, bottom = 0, score = 0;
    logic        cfg_we = 0;
    logic [15:0] cfg_data = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [5:0]  kept_index;
    logic        is_last;
    logic        none_kept;

    kept_scoreboard sb;
    int  cycles = 0;
    int  starts = 0;
    int  loads = 0;
    bit  quiet = 0;      // no idling on either side
    bit  hold_off = 0;   // receiver long stall requested

    greedy_box_suppression DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_command(command), .i_left(left), .i_top(top),
        .i_right(right), .i_bottom(bottom), .i_score(score),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_kept_index(kept_index), .o_is_last(is_last), .o_none_kept(none_kept)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Watchdog: stops the run and reports failure if the simulation goes on too long
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("greedy_box_suppression verification failed");
            $finish;
        end
    end

    // Output monitor, sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(kept_index, is_last, none_kept);
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ready <= 0;
                for (n = 0; n < 400; n++) @(negedge clk);
                hold_off = 0;
            end else begin
                out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
            end
        end
    end

    // Present one transaction and wait for its acceptance; gaps at random
    task automatic send(gbs_pkg::t_cmd cmd, gbs_pkg::t_box b, logic [15:0] s);
        while (!quiet && $urandom_range(99) < 38) @(negedge clk);
        in_valid = 1'b1;
        command <= cmd;
        left <= b.left; top <= b.top; right <= b.right; bottom <= b.bottom;
        score <= s;
        do @(posedge clk); while (!in_ready);
        sb.note_command(cmd, b, s);
        if (cmd == gbs_pkg::t_CMD_START) starts++; else loads++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every predicted result has arrived, then let the block settle
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        drain();
        cfg_we <= 1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.thresh = v;
    endtask

    // Random box: mostly clustered so overlaps are common, sometimes wild
    function automatic gbs_pkg::t_box rand_box();
        gbs_pkg::t_box b;
        int cx;
        int cy;
        if ($urandom_range(9) == 0) begin
            b.left = 16'($urandom); b.top = 16'($urandom);
            b.right = 16'($urandom); b.bottom = 16'($urandom);
        end else begin
            cx = $urandom_range(800);
            cy = $urandom_range(800);
            b.left = 16'(cx);
            b.top = 16'(cy);
            b.right = 16'(cx + $urandom_range(400));
            b.bottom = 16'(cy + $urandom_range(400));
        end
        return b;
    endfunction

    function automatic gbs_pkg::t_box mk(int l, int t, int r, int bt);
        gbs_pkg::t_box b;
        b.left = 16'(l); b.top = 16'(t); b.right = 16'(r); b.bottom = 16'(bt);
        return b;
    endfunction

    initial begin
        gbs_pkg::t_box z;
        int n;
        sb = new();
        z = mk(0, 0, 0, 0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // ---- directed part ----
        send(gbs_pkg::t_CMD_START, z, 16'd0);                          // empty start
        send(gbs_pkg::t_CMD_LOAD, mk(0, 0, 160, 160), 16'hFFFF);
        send(gbs_pkg::t_CMD_LOAD, mk(16, 16, 176, 176), 16'hFFFF);     // equal score
        send(gbs_pkg::t_CMD_LOAD, mk(1000, 1000, 1100, 1100), 16'd0);  // disjoint
        send(gbs_pkg::t_CMD_LOAD, mk(-32768, -32768, 32767, 32767), 16'h8000);
        send(gbs_pkg::t_CMD_LOAD, mk(0, 0, -16, -16), 16'd5);          // zero union
        send(gbs_pkg::t_CMD_LOAD, mk(32767, 32767, -32768, -32768), 16'd7); // neg area
        send(gbs_pkg::t_CMD_START, z, 16'd0);
        write_threshold(16'h0000);
        send(gbs_pkg::t_CMD_LOAD, mk(0, 0, 100, 100), 16'd10);
        send(gbs_pkg::t_CMD_LOAD, mk(200, 200, 300, 300), 16'd20);
        send(gbs_pkg::t_CMD_START, z, 16'd0);
        write_threshold(16'hFFFF);
        send(gbs_pkg::t_CMD_LOAD, mk(0, 0, 100, 100), 16'd10);
        send(gbs_pkg::t_CMD_LOAD, mk(0, 0, 100, 100), 16'd10);         // identical
        send(gbs_pkg::t_CMD_START, z, 16'd0);
        // store full: 66 loads, the last two ignored
        write_threshold(gbs_pkg::ThreshReset);
        quiet = 1;
        for (n = 0; n < 66; n++) send(gbs_pkg::t_CMD_LOAD, rand_box(), 16'($urandom));
        send(gbs_pkg::t_CMD_START, z, 16'd0);
        quiet = 0;

        // ---- random part: groups of loads closed by a start ----
        while (loads + starts < 500) begin
            if (starts % 6 == 0)
                write_threshold(($urandom_range(3) == 0) ? 16'($urandom)
                                : 16'($urandom_range(16384, 49152)));
            if (starts == 20) quiet = 1;
            if (starts == 30) quiet = 0;
            if (starts == 25) hold_off = 1;  // receiver stalls while loads queue
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
            repeat (n) begin
                if ($urandom_range(9) == 0)
                    send(gbs_pkg::t_CMD_LOAD, rand_box(),
                         16'($urandom_range(3) * 16'h5555));
                else
                    send(gbs_pkg::t_CMD_LOAD, rand_box(), 16'($urandom));
            end
            send(gbs_pkg::t_CMD_START, z, 16'd0);
            if (starts == 35) drain();   // sender pauses until all results are in
        end
        write_threshold(16'h0000);       // end at the low extreme
        send(gbs_pkg::t_CMD_LOAD, rand_box(), 16'd1);
        send(gbs_pkg::t_CMD_START, z, 16'd0);

        drain();
        $display("Covered %0d loads and %0d starts, %0d results checked,", loads, starts,
                 sb.checked);
        $display("thresholds from 0 to full scale, empty and full stores.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("greedy_box_suppression verification clean");
        else
            $display("greedy_box_suppression verification failed");
        $finish;
    end
endmodule
